// ===== hdl/i2c_master_register_access_assert.svh =====
// assertion macros used by the i2c master core
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// clocked check, masked while reset is asserted
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds across reset
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// types and constants of the i2c master register access block
package i2cm_pkg;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [2:0] SEG_IDLE   = 3'd0;
    localparam logic [2:0] SEG_DEV    = 3'd1;
    localparam logic [2:0] SEG_REG    = 3'd2;
    localparam logic [2:0] SEG_DATA   = 3'd3;
    localparam logic [2:0] SEG_RSTART = 3'd4;
    localparam logic [2:0] SEG_DEVR   = 3'd5;
    localparam logic [2:0] SEG_READ   = 3'd6;
    localparam logic [2:0] SEG_STOP   = 3'd7;

    localparam logic [4:0] BURST_MAX = 5'd16;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [4:0] read_count;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
    } t_out_item;

endpackage

// ===== hdl/i2cm_core.sv =====
`timescale 1ns / 1ps
// bus sequencer state, phase register and per-tick next-state logic
`include "i2c_master_register_access_assert.svh"
module i2cm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_accept,
    input  i2cm_pkg::t_in_item  i_item,
    output i2cm_pkg::t_out_item o_res
);
    import i2cm_pkg::*;

    logic [15:0] r_phase_ticks;
    logic [2:0]  r_seg, n_seg;
    logic [2:0]  r_sub, n_sub;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [4:0]  r_left, n_left;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_data, n_data;
    logic        r_mode, n_mode;
    logic [15:0] r_div, n_div;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;

    logic        w_busy;
    logic [16:0] w_ph;
    logic [16:0] w_div_inc;
    logic [4:0]  w_cnt;
    logic [2:0]  w_base;
    logic        w_last;
    logic [7:0]  w_rx;
    t_out_item   w_res;

    assign w_busy    = ({r_seg, r_sub} != 6'd0);
    assign w_ph      = (r_phase_ticks == 16'd0) ? 17'd1 : {1'b0, r_phase_ticks};
    assign w_div_inc = {1'b0, r_div} + 17'd1;
    assign w_base    = (r_seg == SEG_IDLE) ? 3'd1 : 3'd0;
    assign w_last    = (r_left <= 5'd1);
    assign w_rx      = {r_shift[6:0], i_item.sda_in};

    always_comb begin
        priority if (i_item.read_count == 5'd0) begin
            w_cnt = 5'd1;
        end else if (i_item.read_count > BURST_MAX) begin
            w_cnt = BURST_MAX;
        end else begin
            w_cnt = i_item.read_count;
        end
    end

    always_comb begin
        n_seg   = r_seg;
        n_sub   = r_sub;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_left  = r_left;
        n_dev   = r_dev;
        n_reg   = r_reg;
        n_data  = r_data;
        n_mode  = r_mode;
        n_div   = r_div;
        n_scl   = r_scl;
        n_sda   = r_sda;

        w_res            = '0;
        w_res.scl        = r_scl;
        w_res.sda_out    = r_sda;
        w_res.busy_res   = w_busy;

        if (!w_busy) begin
            n_div = '0;
            if (i_item.mode == MODE_WRITE || i_item.mode == MODE_READ) begin
                n_dev  = i_item.dev_addr;
                n_reg  = i_item.reg_addr;
                n_data = i_item.write_data;
                n_mode = (i_item.mode == MODE_READ);
                n_left = w_cnt;
                n_seg  = SEG_IDLE;
                n_sub  = 3'd1;
                n_scl  = 1'b1;
                n_sda  = 1'b1;
            end
        end else if (w_div_inc < w_ph) begin
            n_div = w_div_inc[15:0];
        end else begin
            n_div = '0;
            unique case (r_seg)
                SEG_IDLE, SEG_RSTART: begin
                    priority if (r_sub == w_base || r_sub == w_base + 3'd1) begin
                        n_sub = r_sub + 3'd1;
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                    end else if (r_sub == w_base + 3'd2) begin
                        n_seg   = (r_seg == SEG_IDLE) ? SEG_DEV : SEG_DEVR;
                        n_shift = (r_seg == SEG_IDLE) ? r_dev : r_dev + 8'd1;
                        n_bit   = '0;
                        n_sub   = 3'd0;
                        n_scl   = 1'b0;
                    end else begin
                        n_seg = SEG_IDLE;
                        n_sub = 3'd0;
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                    end
                end
                SEG_DEV, SEG_REG, SEG_DATA, SEG_DEVR: begin
                    case (r_sub)
                        3'd0: begin
                            n_sub = 3'd1;
                            n_scl = 1'b0;
                            n_sda = r_shift[7];
                        end
                        3'd1: begin
                            n_sub = 3'd2;
                            n_scl = 1'b1;
                        end
                        3'd2: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_scl   = 1'b0;
                            if (r_bit == 3'd7) begin
                                n_bit = '0;
                                n_sub = 3'd3;
                            end else begin
                                n_bit = r_bit + 3'd1;
                                n_sub = 3'd0;
                            end
                        end
                        3'd3: begin
                            n_sub = 3'd4;
                            n_scl = 1'b0;
                            n_sda = 1'b1;
                        end
                        3'd4: begin
                            n_sub = 3'd5;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        3'd5: begin
                            // slave ack is not sampled here; it is ignored
                            n_sub = 3'd6;
                            n_scl = 1'b0;
                            n_sda = 1'b1;
                        end
                        3'd6: begin
                            n_sub = 3'd0;
                            n_scl = 1'b0;
                            unique case (r_seg)
                                SEG_DEV: begin
                                    n_seg   = SEG_REG;
                                    n_shift = r_reg;
                                    n_bit   = '0;
                                end
                                SEG_REG: begin
                                    if (r_mode) begin
                                        n_seg = SEG_RSTART;
                                        n_scl = 1'b1;
                                        n_sda = 1'b1;
                                    end else begin
                                        n_seg   = SEG_DATA;
                                        n_shift = r_data;
                                        n_bit   = '0;
                                    end
                                end
                                SEG_DATA: begin
                                    n_seg = SEG_STOP;
                                end
                                default: begin
                                    n_seg   = SEG_READ;
                                    n_shift = '0;
                                    n_bit   = '0;
                                    n_sda   = 1'b1;
                                end
                            endcase
                        end
                        default: begin
                            n_seg = SEG_IDLE;
                            n_sub = 3'd0;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                    endcase
                end
                SEG_READ: begin
                    case (r_sub)
                        3'd0: begin
                            n_sub = 3'd1;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        3'd1: begin
                            n_shift = w_rx;
                            n_scl   = 1'b0;
                            n_sda   = 1'b1;
                            if (r_bit == 3'd7) begin
                                n_bit            = '0;
                                n_sub            = 3'd2;
                                w_res.read_valid = 1'b1;
                                w_res.read_data  = w_rx;
                                w_res.read_last  = w_last;
                            end else begin
                                n_bit = r_bit + 3'd1;
                                n_sub = 3'd0;
                            end
                        end
                        3'd2: begin
                            // ack every byte but nack the last
                            n_sub = 3'd3;
                            n_scl = 1'b0;
                            n_sda = w_last;
                        end
                        3'd3: begin
                            n_sub = 3'd4;
                            n_scl = 1'b1;
                        end
                        3'd4: begin
                            n_sub = 3'd5;
                            n_scl = 1'b0;
                        end
                        3'd5: begin
                            n_sub = 3'd0;
                            n_scl = 1'b0;
                            if (w_last) begin
                                n_seg = SEG_STOP;
                            end else begin
                                n_left  = r_left - 5'd1;
                                n_shift = '0;
                                n_sda   = 1'b1;
                            end
                        end
                        default: begin
                            n_seg = SEG_IDLE;
                            n_sub = 3'd0;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                    endcase
                end
                SEG_STOP: begin
                    case (r_sub)
                        3'd0: begin
                            n_sub = 3'd1;
                            n_scl = 1'b0;
                            n_sda = 1'b0;
                        end
                        3'd1: begin
                            n_sub = 3'd2;
                            n_scl = 1'b1;
                            n_sda = 1'b0;
                        end
                        3'd2: begin
                            n_sub = 3'd3;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        3'd3: begin
                            w_res.done_res = 1'b1;
                            n_seg = SEG_IDLE;
                            n_sub = 3'd0;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        default: begin
                            n_seg = SEG_IDLE;
                            n_sub = 3'd0;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= 16'd1;
            r_seg   <= SEG_IDLE;
            r_sub   <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_left  <= '0;
            r_dev   <= '0;
            r_reg   <= '0;
            r_data  <= '0;
            r_mode  <= 1'b0;
            r_div   <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_data;
            end
            if (i_accept) begin
                r_seg   <= n_seg;
                r_sub   <= n_sub;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_left  <= n_left;
                r_dev   <= n_dev;
                r_reg   <= n_reg;
                r_data  <= n_data;
                r_mode  <= n_mode;
                r_div   <= n_div;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
            end
        end
    end

    assign o_res = w_res;

    `I2CM_ASSERT(a_idle_div_clear, i_clk, i_rst_n, (!w_busy) |-> (r_div == 16'd0), "divider not clear while idle")
    `I2CM_ASSERT(a_idle_released, i_clk, i_rst_n, (!w_busy) |-> (r_scl && r_sda), "bus not released while idle")
    `I2CM_ASSERT(a_burst_bound, i_clk, i_rst_n, r_left <= BURST_MAX, "burst count above limit")
    `I2CM_ASSERT(a_done_to_idle, i_clk, i_rst_n, (i_accept && w_res.done_res) |=> !w_busy, "stop did not return to idle")
    `I2CM_ASSERT(a_rx_only_read, i_clk, i_rst_n, w_res.read_valid |-> (r_seg == SEG_READ), "read byte outside read segment")

endmodule

// ===== hdl/i2cm_out_stage.sv =====
`timescale 1ns / 1ps
// result register with valid and stall toward the consumer
module i2cm_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cm_pkg::t_out_item i_res,
    input  logic                i_stall,
    output logic                o_full_stall,
    output logic                o_valid,
    output i2cm_pkg::t_out_item o_res
);
    import i2cm_pkg::*;

    logic      r_valid, n_valid;
    t_out_item r_res;

    assign o_full_stall = r_valid && i_stall;

    always_comb begin
        priority if (i_load) begin
            n_valid = 1'b1;
        end else if (i_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hdl/i2c_master_register_access.sv =====
`timescale 1ns / 1ps
// top level of the i2c master register access block. every input item is one
// bus tick: it may start a register write or a burst read when the bus is idle,
// and it carries the sampled sda level. the block takes one item per clock cycle
// while it is not stalled and returns exactly one result item per input item,
// in the cycle after the item is taken, from a result register; a stalled result
// only holds the input off while the result register is still occupied. the rate
// is set by the combinational sequencer step between the phase state registers
// and the result register. each pin phase lasts phase_ticks items (zero acts as
// one); write phase_ticks only while no transaction is in progress.
module i2c_master_register_access (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  i2cm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import i2cm_pkg::*;

    logic      w_accept;
    logic      w_full_stall;
    t_out_item w_res;

    assign o_in_stall  = w_full_stall;
    assign w_accept    = i_in_valid && !w_full_stall;
    assign o_cfg_ready = 1'b1;

    i2cm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_item     (i_in_data),
        .o_res      (w_res)
    );

    i2cm_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_res        (w_res),
        .i_stall      (i_out_stall),
        .o_full_stall (w_full_stall),
        .o_valid      (o_out_valid),
        .o_res        (o_out_data)
    );

endmodule
